### src/adsp_pkg.sv
// shared constants and types for the audio dsp command port
// no dependencies
`timescale 1ns / 1ps

package adsp_pkg;

    // mixer register file
    localparam int MIXER_REGS = 256;
    localparam int MIX_IDX_W  = 8;
    localparam int MIX_AW     = $clog2(MIXER_REGS);

    // port offsets
    localparam logic [3:0] PORT_MIX_INDEX = 4'd4;
    localparam logic [3:0] PORT_MIX_DATA  = 4'd5;
    localparam logic [3:0] PORT_RESET     = 4'd6;
    localparam logic [3:0] PORT_READ      = 4'd10;
    localparam logic [3:0] PORT_WRITE     = 4'd12;
    localparam logic [3:0] PORT_STATUS    = 4'd14;

    // access kinds
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // command bytes
    localparam logic [7:0] CMD_TIME_CONST = 8'h40;
    localparam logic [7:0] CMD_OUT_RATE   = 8'h41;
    localparam logic [7:0] CMD_XFER_16    = 8'hB6;
    localparam logic [7:0] CMD_XFER_8     = 8'hC6;
    localparam logic [7:0] CMD_SPK_ON     = 8'hD1;
    localparam logic [7:0] CMD_SPK_OFF    = 8'hD3;
    localparam logic [7:0] CMD_STOP       = 8'hD5;
    localparam logic [7:0] CMD_VERSION    = 8'hE1;

    // reply and status bytes
    localparam logic [7:0] READY_BYTE  = 8'hAA;
    localparam logic [7:0] STATUS_FULL = 8'h80;

    // configuration register indexes
    localparam logic CFG_VER_MAJOR = 1'b0;
    localparam logic CFG_VER_MINOR = 1'b1;

    // request from the command decode to the mixer file
    typedef struct packed {
        logic                 idx_wr;
        logic                 data_wr;
        logic [MIX_IDX_W-1:0] data;
    } mix_req_t;

endpackage

### src/audio_dsp_command_port_top.sv
// audio dsp command port top level: input register, command decode, result register
// depends on adsp_pkg and adsp_mixer
`timescale 1ns / 1ps

// Each bus access word is taken into an input register, decoded in one pass and its
// result word is held in an output register, so one access is accepted every cycle
// while m_ready stays high; an access goes through the input register, then the result register.
// Stalls on the result side back up through the input register. The mixer file keeps
// a valid flag per entry, so it reads as zero right after reset with no clearing pass.
// The version bytes are set through the APB port at byte addresses 0 and 4.
module audio_dsp_command_port_top
    import adsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // access words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [3:0]  s_port_offset,
    input  logic [7:0]  s_write_data,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic        m_data_ready,
    output logic        m_speaker_on,
    output logic        m_playing,
    output logic        m_wide_transfer,
    output logic [7:0]  m_transfer_mode,
    output logic [15:0] m_transfer_count,
    output logic [15:0] m_output_rate,
    output logic [7:0]  m_time_constant_out
);

    // configuration registers
    logic [7:0] ver_major_reg;
    logic [7:0] ver_minor_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ver_major_reg <= 8'd4;
            ver_minor_reg <= 8'd5;
        end else if (cfg_wr) begin
            if (paddr[2] == CFG_VER_MAJOR) begin
                ver_major_reg <= pwdata[7:0];
            end else begin
                ver_minor_reg <= pwdata[7:0];
            end
        end
    end

    assign prdata = {24'h0, (paddr[2] == CFG_VER_MINOR) ? ver_minor_reg : ver_major_reg};

    // input register
    logic       in_vld_reg;
    logic       func_reg;
    logic [3:0] port_reg;
    logic [7:0] wdata_reg;
    logic       proc;

    assign proc    = in_vld_reg && (!m_valid || m_ready);
    assign s_ready = !in_vld_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg  <= s_func;
            port_reg  <= s_port_offset;
            wdata_reg <= s_write_data;
        end
    end

    // command state
    logic        in_reset_reg,  in_reset_next;
    logic [7:0]  pend_cmd_reg,  pend_cmd_next;
    logic [1:0]  args_left_reg, args_left_next;
    logic [7:0]  arg0_reg,      arg0_next;
    logic [7:0]  arg1_reg,      arg1_next;
    logic [7:0]  q0_reg,        q0_next;
    logic [7:0]  q1_reg,        q1_next;
    logic [1:0]  rcount_reg,    rcount_next;
    logic        spk_reg,       spk_next;
    logic        play_reg,      play_next;
    logic        wide_reg,      wide_next;
    logic [7:0]  mode_reg,      mode_next;
    logic [15:0] count_reg,     count_next;
    logic [15:0] rate_reg,      rate_next;
    logic [7:0]  tc_reg,        tc_next;
    logic [7:0]  rd_next;

    mix_req_t             mix_req;
    logic [MIX_IDX_W-1:0] mix_index;
    logic [7:0]           mix_rd;

    adsp_mixer u_mixer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mix_req),
        .index   (mix_index),
        .rd_data (mix_rd)
    );

    always_comb begin
        in_reset_next  = in_reset_reg;
        pend_cmd_next  = pend_cmd_reg;
        args_left_next = args_left_reg;
        arg0_next      = arg0_reg;
        arg1_next      = arg1_reg;
        q0_next        = q0_reg;
        q1_next        = q1_reg;
        rcount_next    = rcount_reg;
        spk_next       = spk_reg;
        play_next      = play_reg;
        wide_next      = wide_reg;
        mode_next      = mode_reg;
        count_next     = count_reg;
        rate_next      = rate_reg;
        tc_next        = tc_reg;
        rd_next        = 8'h00;
        mix_req.idx_wr  = 1'b0;
        mix_req.data_wr = 1'b0;
        mix_req.data    = wdata_reg;

        if (func_reg == FUNC_WRITE) begin
            case (port_reg)
                PORT_MIX_INDEX: begin
                    mix_req.idx_wr = proc;
                end
                PORT_MIX_DATA: begin
                    mix_req.data_wr = proc;
                end
                PORT_RESET: begin
                    if (wdata_reg[0]) begin
                        in_reset_next = 1'b1;
                    end else if (in_reset_reg) begin
                        in_reset_next  = 1'b0;
                        pend_cmd_next  = 8'h00;
                        args_left_next = 2'd0;
                        q0_next        = READY_BYTE;
                        rcount_next    = 2'd1;
                        play_next      = 1'b0;
                        spk_next       = 1'b0;
                    end
                end
                PORT_WRITE: begin
                    if (!in_reset_reg) begin
                        if (args_left_reg != 2'd0) begin
                            args_left_next = args_left_reg - 2'd1;
                            if (pend_cmd_reg == CMD_TIME_CONST) begin
                                tc_next = wdata_reg;
                            end else if (pend_cmd_reg == CMD_OUT_RATE) begin
                                if (args_left_reg == 2'd2) begin
                                    arg0_next = wdata_reg;
                                end else begin
                                    rate_next = {arg0_reg, wdata_reg};
                                end
                            end else if (args_left_reg == 2'd3) begin
                                arg0_next = wdata_reg;
                            end else if (args_left_reg == 2'd2) begin
                                arg1_next = wdata_reg;
                            end else begin
                                mode_next  = arg0_reg;
                                count_next = {wdata_reg, arg1_reg};
                                wide_next  = (pend_cmd_reg == CMD_XFER_16);
                                play_next  = 1'b1;
                            end
                        end else begin
                            pend_cmd_next = wdata_reg;
                            case (wdata_reg)
                                CMD_TIME_CONST: args_left_next = 2'd1;
                                CMD_OUT_RATE:   args_left_next = 2'd2;
                                CMD_XFER_16:    args_left_next = 2'd3;
                                CMD_XFER_8:     args_left_next = 2'd3;
                                CMD_SPK_ON:     spk_next = 1'b1;
                                CMD_SPK_OFF:    spk_next = 1'b0;
                                CMD_STOP:       play_next = 1'b0;
                                CMD_VERSION: begin
                                    case (rcount_reg)
                                        2'd0: begin
                                            q0_next     = ver_major_reg;
                                            q1_next     = ver_minor_reg;
                                            rcount_next = 2'd2;
                                        end
                                        2'd1: begin
                                            q1_next     = ver_major_reg;
                                            rcount_next = 2'd2;
                                        end
                                        default: begin
                                        end
                                    endcase
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
                default: begin
                end
            endcase
        end else begin
            case (port_reg)
                PORT_MIX_INDEX: rd_next = mix_index;
                PORT_MIX_DATA:  rd_next = mix_rd;
                PORT_READ: begin
                    if (rcount_reg != 2'd0) begin
                        rd_next     = q0_reg;
                        q0_next     = q1_reg;
                        rcount_next = rcount_reg - 2'd1;
                    end
                end
                PORT_STATUS: rd_next = (rcount_reg != 2'd0) ? STATUS_FULL : 8'h00;
                default:     rd_next = 8'h00;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_reset_reg  <= 1'b0;
            pend_cmd_reg  <= 8'h00;
            args_left_reg <= 2'd0;
            arg0_reg      <= 8'h00;
            arg1_reg      <= 8'h00;
            rcount_reg    <= 2'd0;
            spk_reg       <= 1'b0;
            play_reg      <= 1'b0;
            wide_reg      <= 1'b0;
            mode_reg      <= 8'h00;
            count_reg     <= 16'h0000;
            rate_reg      <= 16'h0000;
            tc_reg        <= 8'h00;
        end else if (proc) begin
            in_reset_reg  <= in_reset_next;
            pend_cmd_reg  <= pend_cmd_next;
            args_left_reg <= args_left_next;
            arg0_reg      <= arg0_next;
            arg1_reg      <= arg1_next;
            rcount_reg    <= rcount_next;
            spk_reg       <= spk_next;
            play_reg      <= play_next;
            wide_reg      <= wide_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            rate_reg      <= rate_next;
            tc_reg        <= tc_next;
        end
    end

    // reply bytes hold no reset value
    always_ff @(posedge aclk) begin
        if (proc) begin
            q0_reg <= q0_next;
            q1_reg <= q1_next;
        end
    end

    // result register
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (proc) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            m_read_data         <= rd_next;
            m_data_ready        <= (rcount_next != 2'd0);
            m_speaker_on        <= spk_next;
            m_playing           <= play_next;
            m_wide_transfer     <= wide_next;
            m_transfer_mode     <= mode_next;
            m_transfer_count    <= count_next;
            m_output_rate       <= rate_next;
            m_time_constant_out <= tc_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### src/adsp_mixer.sv
// mixer register file: index register, storage, per-entry valid flags
// depends on adsp_pkg
`timescale 1ns / 1ps

module adsp_mixer
    import adsp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mix_req_t             req,
    output logic [MIX_IDX_W-1:0] index,
    output logic [7:0]           rd_data
);

    localparam logic [MIX_IDX_W:0] MIX_LIMIT = (MIX_IDX_W+1)'(MIXER_REGS);

    logic [7:0]           mem [MIXER_REGS];
    logic [MIXER_REGS-1:0] valid_reg;
    logic [MIX_IDX_W-1:0] idx_reg;
    logic [MIX_IDX_W-1:0] idx_next;
    logic [7:0]           mem_q_reg;
    logic                 vld_q_reg;
    logic                 byp_reg;
    logic [7:0]           byp_data_reg;
    logic                 in_range;
    logic                 wr_en;

    assign in_range = {1'b0, idx_reg} < MIX_LIMIT;
    assign idx_next = req.idx_wr ? req.data : idx_reg;
    assign wr_en    = req.data_wr && in_range;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[idx_reg[MIX_AW-1:0]] <= req.data;
        end
        mem_q_reg    <= mem[idx_next[MIX_AW-1:0]];
        byp_data_reg <= req.data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= '0;
            vld_q_reg <= 1'b0;
            byp_reg   <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            vld_q_reg <= valid_reg[idx_next[MIX_AW-1:0]];
            byp_reg   <= wr_en;
            if (wr_en) begin
                valid_reg[idx_reg[MIX_AW-1:0]] <= 1'b1;
            end
        end
    end

    // entry just written is forwarded until the read port catches up
    always_comb begin
        if (!in_range) begin
            rd_data = 8'h00;
        end else if (byp_reg) begin
            rd_data = byp_data_reg;
        end else if (vld_q_reg) begin
            rd_data = mem_q_reg;
        end else begin
            rd_data = 8'h00;
        end
    end

    assign index = idx_reg;

endmodule
